// File: src/afrf_pkg.sv
`default_nettype none

package afrf_pkg;

    // buffer limit default and field widths
    localparam int FRAME_BUF_BYTES_DEF = 64;
    localparam int FRAME_LEN_W         = 7;
    localparam int KIND_W              = 3;
    localparam int FB_COUNT            = 7;   // frame bytes 2..8 are kept
    localparam int FB_FIRST            = 2;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    // register reset values
    localparam logic [7:0] HEAD_RESET = 8'h66;
    localparam logic [7:0] TAIL_RESET = 8'hFD;

    // register indexes
    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    // command codes
    localparam logic [7:0] CMD_ALARM       = 8'h68;
    localparam logic [7:0] CMD_FAULT       = 8'h03;
    localparam logic [7:0] CMD_RESET       = 8'h20;
    localparam logic [7:0] CMD_READING     = 8'h10;
    localparam logic [7:0] CMD_ALARM_VALUE = 8'h17;

    // status value of the alarm reading class
    localparam logic [7:0] STATUS_ALARM = 8'h01;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_RESET   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIRE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READING = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd4;

    // completed frame handed from the front end to the decoder
    typedef struct packed {
        logic [FB_COUNT-1:0][7:0]  bytes;
        logic [FRAME_LEN_W-1:0]    len;
    } frame_rec_t;

endpackage

`default_nettype wire

// File: src/afrf_front.sv
`default_nettype none

module afrf_front
    import afrf_pkg::*;
#(
    parameter int FRAME_BUF_BYTES = FRAME_BUF_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] head_byte,
    input  wire logic [7:0] tail_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       q_full,
    output logic            push,
    output frame_rec_t      rec
);

    localparam int CNT_W = $clog2(FRAME_BUF_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_BUF_BYTES - 2);

    logic                      in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [FB_COUNT-1:0][7:0]  work_reg, work_next;
    logic [FB_COUNT-1:0][7:0]  frame_reg, frame_next;
    logic [FB_COUNT-1:0][7:0]  merged;
    logic [CNT_W-1:0]          count_inc;
    logic                      accept;
    logic                      is_tail;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign count_inc = count_reg + 1'b1;
    assign is_tail   = (rx_byte == tail_byte);

    always_comb
    begin
        for (int i = 0; i < FB_COUNT; i++)
        begin
            work_next[i] = (accept && count_reg == CNT_W'(i + FB_FIRST)) ? rx_byte
                                                                          : work_reg[i];
            // positions past the frame length keep the older frame's bytes
            merged[i]    = (CNT_W'(i + FB_FIRST) < count_inc) ? work_next[i] : frame_reg[i];
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        frame_next    = frame_reg;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == head_byte)
                begin
                    in_frame_next = 1'b1;
                    count_next    = count_inc;
                end
                else
                begin
                    count_next = '0;
                end
            end
            else if (!is_tail)
            begin
                if (count_inc >= CNT_LIMIT)
                begin
                    in_frame_next = 1'b0;
                    count_next    = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            else
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                frame_next    = merged;
            end
        end
    end

    assign push      = accept && in_frame_reg && is_tail;
    assign rec.bytes = merged;
    assign rec.len   = FRAME_LEN_W'(count_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            work_reg     <= '0;
            frame_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            work_reg     <= work_next;
            frame_reg    <= frame_next;
        end
    end

endmodule

`default_nettype wire

// File: src/afrf_queue.sv
`default_nettype none

module afrf_queue
    import afrf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_rec_t push_rec,
    output logic            full,
    output logic            q_valid,
    output frame_rec_t      q_rec,
    input  wire logic       pop
);

    frame_rec_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: src/afrf_back.sv
`default_nettype none

module afrf_back
    import afrf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire frame_rec_t             q_rec,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [KIND_W-1:0]           event_kind,
    output logic [7:0]                  controller_addr,
    output logic [7:0]                  loop_number,
    output logic [7:0]                  device_number,
    output logic [15:0]                 reading_value,
    output logic [7:0]                  status_byte,
    output logic [FRAME_LEN_W-1:0]      frame_length
);

    logic                    out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]       kind_reg;
    logic [7:0]              ctrl_reg, loop_reg, dev_reg, status_reg;
    logic [15:0]             value_reg;
    logic [FRAME_LEN_W-1:0]  len_reg;
    logic [23:0]             last_addr_reg;
    logic                    alarm_sent_reg, alarm_sent_next;
    logic                    normal_sent_reg, normal_sent_next;

    logic [7:0]              cmd;
    logic [23:0]             addr;
    logic [KIND_W-1:0]       kind;
    logic                    emit;
    logic                    has_reading;

    assign cmd  = q_rec.bytes[1];
    assign addr = {q_rec.bytes[0], q_rec.bytes[2], q_rec.bytes[3]};
    assign pop  = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        kind             = KIND_RESET;
        emit             = 1'b0;
        alarm_sent_next  = 1'b0;
        normal_sent_next = 1'b0;
        if (cmd == CMD_READING)
        begin
            kind             = KIND_READING;
            alarm_sent_next  = alarm_sent_reg;
            normal_sent_next = normal_sent_reg;
            if (addr == last_addr_reg)
            begin
                if (q_rec.bytes[6] == STATUS_ALARM)
                begin
                    emit            = !alarm_sent_reg;
                    alarm_sent_next = 1'b1;
                end
                else
                begin
                    emit             = !normal_sent_reg;
                    normal_sent_next = 1'b1;
                end
            end
            else
            begin
                // new address: forget both classes, nothing forwarded
                alarm_sent_next  = 1'b0;
                normal_sent_next = 1'b0;
            end
        end
        else
        begin
            emit = 1'b1;
            priority case (cmd)
                CMD_RESET:       kind = KIND_RESET;
                CMD_ALARM:       kind = KIND_FIRE;
                CMD_FAULT:       kind = KIND_FAULT;
                CMD_ALARM_VALUE: kind = KIND_VALUE;
                default:         emit = 1'b0;
            endcase
        end
    end

    assign has_reading = (kind == KIND_READING) || (kind == KIND_VALUE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg   <= kind;
            ctrl_reg   <= q_rec.bytes[0];
            loop_reg   <= (kind == KIND_RESET) ? 8'd0 : q_rec.bytes[2];
            dev_reg    <= (kind == KIND_RESET) ? 8'd0 : q_rec.bytes[3];
            value_reg  <= has_reading ? {q_rec.bytes[4], q_rec.bytes[5]} : 16'd0;
            status_reg <= has_reading ? q_rec.bytes[6] : 8'd0;
            len_reg    <= q_rec.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            last_addr_reg   <= '0;
            alarm_sent_reg  <= 1'b0;
            normal_sent_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                last_addr_reg   <= addr;
                alarm_sent_reg  <= alarm_sent_next;
                normal_sent_reg <= normal_sent_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = kind_reg;
    assign controller_addr = ctrl_reg;
    assign loop_number     = loop_reg;
    assign device_number   = dev_reg;
    assign reading_value   = value_reg;
    assign status_byte     = status_reg;
    assign frame_length    = len_reg;

endmodule

`default_nettype wire

// File: src/alarm_frame_receiver_filter_top.sv
// path: a frame passes from the tail byte transaction through the frame queue and then
//   the output register before its event transaction
// throughput: one byte per cycle; the front end stalls only while the two-entry
//   frame queue is full, which needs the output held back over two tails
// reset: rst_n is asynchronous, active low; it idles the receiver, clears the
//   kept frame bytes, last address and reading classes, and loads the default
//   head and tail bytes
`default_nettype none

module alarm_frame_receiver_filter_top
    import afrf_pkg::*;
#(
    parameter int FRAME_BUF_BYTES = FRAME_BUF_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    // received byte channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    // event channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [KIND_W-1:0]           event_kind,
    output logic [7:0]                  controller_addr,
    output logic [7:0]                  loop_number,
    output logic [7:0]                  device_number,
    output logic [15:0]                 reading_value,
    output logic [7:0]                  status_byte,
    output logic [FRAME_LEN_W-1:0]      frame_length
);

    // frame delimiter registers
    logic [7:0]  head_reg, tail_reg;
    logic        cfg_wr;
    logic        reg_sel;

    // front end to queue to decoder
    logic        push;
    frame_rec_t  push_rec;
    logic        q_full;
    logic        q_valid;
    frame_rec_t  q_rec;
    logic        pop;

    // register index is the word address; writes land in the access phase
    assign reg_sel = paddr[APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = {{(APB_DATA_W-8){1'b0}}, (reg_sel == REG_TAIL) ? tail_reg : head_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_HEAD: head_reg <= pwdata[7:0];
                REG_TAIL: tail_reg <= pwdata[7:0];
            endcase
        end
    end

    // front end: delimits frames, captures bytes 2..8, merges with the last frame
    afrf_front #(
        .FRAME_BUF_BYTES (FRAME_BUF_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .push      (push),
        .rec       (push_rec)
    );

    // short queue of completed frames
    afrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_rec    (q_rec),
        .pop      (pop)
    );

    // back end: command decode, reading filter, output register
    afrf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_rec           (q_rec),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_kind      (event_kind),
        .controller_addr (controller_addr),
        .loop_number     (loop_number),
        .device_number   (device_number),
        .reading_value   (reading_value),
        .status_byte     (status_byte),
        .frame_length    (frame_length)
    );

`ifndef SYNTHESIS
    // no frame is written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("frame pushed into full queue");

    // a reset event carries no loop or device
    a_reset_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_RESET) |->
            (loop_number == 8'd0 && device_number == 8'd0))
        else $error("reset event with loop or device set");

    // a frame holds at least its head and tail
    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_length >= FRAME_LEN_W'(2))
        else $error("event with short frame length");

    // only reading kinds carry a value
    a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reading_value != 16'd0) |->
            (event_kind == KIND_READING || event_kind == KIND_VALUE))
        else $error("reading value on a non-reading event");
`endif

endmodule

`default_nettype wire
